### hdl/assert_macros.svh
// Assertion macros used by the packed pixel unpacker core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising edge outside reset.
`define PPU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("packed pixel unpacker assertion failed");

// A condition that must be followed by another one in the next cycle.
`define PPU_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("packed pixel unpacker assertion failed");

`endif

### hdl/ppu_pkg.sv
// Types, register codes and scaling constants of the packed pixel unpacker.
package ppu_pkg;

  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_SLOTS  = 4;
  localparam int FRAME_W    = 24;
  localparam int COLOR_W    = 24;
  localparam int HELD_W     = 6;
  localparam int PROD_W     = 40;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_INDEXED_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT0_BITS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT1_BITS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT2_BITS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT3_BITS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_ROLES   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 3'd7;

  // Slot roles.
  localparam logic [1:0] ROLE_RED   = 2'd0;
  localparam logic [1:0] ROLE_GREEN = 2'd1;
  localparam logic [1:0] ROLE_BLUE  = 2'd2;
  localparam logic [1:0] ROLE_ALPHA = 2'd3;

  // 8-bit scaling: (v*K) >> 24, K = 255 * (floor(2^24 / (2^s - 1)) + 1) for s of 2-7;
  // K1 = 255 * 2^24, K8 = 2^24; the error stays below one step for fields up to 7 bits.
  localparam logic [31:0] SCALE_K1 = 32'hFF00_0000;
  localparam logic [31:0] SCALE_K2 = 32'(255 * ((1 << 24) / 3 + 1));
  localparam logic [31:0] SCALE_K3 = 32'(255 * ((1 << 24) / 7 + 1));
  localparam logic [31:0] SCALE_K4 = 32'(255 * ((1 << 24) / 15 + 1));
  localparam logic [31:0] SCALE_K5 = 32'(255 * ((1 << 24) / 31 + 1));
  localparam logic [31:0] SCALE_K6 = 32'(255 * ((1 << 24) / 63 + 1));
  localparam logic [31:0] SCALE_K7 = 32'(255 * ((1 << 24) / 127 + 1));
  localparam logic [31:0] SCALE_K8 = 32'h0100_0000;

  typedef struct packed {
    logic                          indexed_mode;
    logic [3:0]                    index_bits;
    logic [NUM_SLOTS-1:0][3:0]     slot_bits;
    logic [7:0]                    slot_roles;
    logic [FRAME_W-1:0]            frame_pixels;
  } ppu_cfg_t;

  localparam ppu_cfg_t CFG_RESET = '{
    indexed_mode: 1'b0,
    index_bits:   4'd8,
    slot_bits:    {NUM_SLOTS{4'd8}},
    slot_roles:   8'd228,
    frame_pixels: 24'd307200
  };

  typedef enum logic {
    CMD_PIXEL     = 1'b0,
    CMD_PAL_WRITE = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic               sof;
    logic [7:0]         data_byte;
    logic [7:0]         pal_index;
    logic [COLOR_W-1:0] pal_color;
  } ppu_cmd_t;

  typedef struct packed {
    logic              idle;
    logic [HELD_W-1:0] held;
    logic [HELD_W-1:0] pix_bits;
  } ppu_sts_t;

  function automatic logic [31:0] scale_k(input logic [3:0] s);
    logic [31:0] k;
    unique case (s)
      4'd1:    k = SCALE_K1;
      4'd2:    k = SCALE_K2;
      4'd3:    k = SCALE_K3;
      4'd4:    k = SCALE_K4;
      4'd5:    k = SCALE_K5;
      4'd6:    k = SCALE_K6;
      4'd7:    k = SCALE_K7;
      4'd8:    k = SCALE_K8;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [3:0] clamp8(input logic [3:0] v);
    return (v > 4'd8) ? 4'd8 : v;
  endfunction

endpackage

### hdl/packed_pixel_unpacker_core.sv
// Top level of the packed pixel unpacker: configuration registers, front and back ends.
//
// Use: framebuffer bytes and palette writes enter on the s_axis channel; every
// byte is appended to a least-significant-bit-first stream that is cut into
// pixels, each leaving as one red/green/blue item on m_axis, tlast marking
// the last pixel a byte completes. Registers are to be written through cfg_we_i,
// cfg_index_i and cfg_wdata_i only while the block is idle, which the block does not
// enforce; any write other than frame_pixels drops the partial bits held in the stream.
// Path: the first pixel of a byte leaves the unpack engine through the first stage,
// the second stage and the result register onto m_axis; the engine takes the byte from
// the two-entry command queue, at the earliest in the cycle after s_axis accepts it.
// Throughput: the unpack engine loads a byte, then cuts one pixel a cycle from it while
// m_axis is not held off, and takes the next command only once the byte is used up;
// a palette write is done while the engine is idle. Bytes that complete no pixel
// and pixels beyond the frame still pass through the engine but yield no item.
// Reset: registers return to their defaults, the stream and pixel count are
// cleared and every palette entry reads as zero from the first cycle on.
// Stall: while m_axis is held off the engine and its pipeline freeze, and
// the input keeps accepting until the command queue is full.
`include "assert_macros.svh"

module packed_pixel_unpacker_core
  import ppu_pkg::*;
#(
  parameter int PALETTE_DEPTH  = 256,
  parameter int MAX_PIXEL_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // data_byte [7:0], palette_index [15:8], palette_color [39:16]
  input  logic [39:0]          s_axis_tdata_i,
  // opcode [0], start_of_frame [1]
  input  logic [1:0]           s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // red [7:0], green [15:8], blue [23:16]
  output logic [23:0]          m_axis_tdata_o,
  output logic                 m_axis_tlast_o
);

  ppu_cfg_t cfg_q, cfg_d;
  logic     cfg_clear;
  logic     cmd_valid;
  ppu_cmd_t cmd;
  logic     cmd_pop;
  ppu_sts_t bk_sts;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_INDEXED_MODE: cfg_d.indexed_mode = cfg_wdata_i[0];
        REG_INDEX_BITS:   cfg_d.index_bits   = cfg_wdata_i[3:0];
        REG_SLOT0_BITS:   cfg_d.slot_bits[0] = cfg_wdata_i[3:0];
        REG_SLOT1_BITS:   cfg_d.slot_bits[1] = cfg_wdata_i[3:0];
        REG_SLOT2_BITS:   cfg_d.slot_bits[2] = cfg_wdata_i[3:0];
        REG_SLOT3_BITS:   cfg_d.slot_bits[3] = cfg_wdata_i[3:0];
        REG_SLOT_ROLES:   cfg_d.slot_roles   = cfg_wdata_i[7:0];
        REG_FRAME_PIXELS: cfg_d.frame_pixels = cfg_wdata_i[FRAME_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  // Every layout register realigns the stream; the frame length does not.
  assign cfg_clear = cfg_we_i && (cfg_index_i != REG_FRAME_PIXELS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ppu_front #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  ppu_back #(
    .PALETTE_DEPTH  (PALETTE_DEPTH),
    .MAX_PIXEL_BITS (MAX_PIXEL_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cfg_clear_i     (cfg_clear),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .sts_o           (bk_sts),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  `PPU_ASSERT(a_pop_needs_cmd, clk_i, rst_ni, cmd_pop |-> cmd_valid)
  `PPU_ASSERT(a_pop_only_idle, clk_i, rst_ni, cmd_pop |-> bk_sts.idle)
  `PPU_ASSERT(a_idle_short_of_pixel, clk_i, rst_ni,
              bk_sts.idle |-> ((bk_sts.held < bk_sts.pix_bits) || (bk_sts.pix_bits == '0)))
  `PPU_ASSERT_NEXT(a_clear_realigns, clk_i, rst_ni, cfg_clear,
                   (bk_sts.idle && (bk_sts.held == '0)))

endmodule

### hdl/ppu_front.sv
// Input side: accepts items, classifies them into commands and queues them.
module ppu_front
  import ppu_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  // data_byte [7:0], palette_index [15:8], palette_color [39:16]
  input  logic [39:0]    s_axis_tdata_i,
  // opcode [0], start_of_frame [1]
  input  logic [1:0]     s_axis_tuser_i,
  output logic           cmd_valid_o,
  output ppu_cmd_t       cmd_o,
  input  logic           cmd_pop_i
);

  ppu_cmd_t            in_cmd;
  ppu_cmd_t            q_mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;
  logic                accept;
  logic                keep;
  logic                push;

  assign in_cmd.kind      = cmd_kind_e'(s_axis_tuser_i[0]);
  assign in_cmd.sof       = s_axis_tuser_i[1];
  assign in_cmd.data_byte = s_axis_tdata_i[7:0];
  assign in_cmd.pal_index = s_axis_tdata_i[15:8];
  assign in_cmd.pal_color = s_axis_tdata_i[39:16];

  // A palette write beyond the palette is accepted but never queued.
  assign keep = (in_cmd.kind == CMD_PIXEL) ||
                ({1'b0, in_cmd.pal_index} < 9'(PALETTE_DEPTH));

  assign s_axis_tready_o = (count_q != QCNT_W'(QDEPTH));
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign push            = accept && keep;
  assign cmd_valid_o     = (count_q != '0);
  assign cmd_o           = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (cmd_pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push, cmd_pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

### hdl/ppu_back.sv
// Execution side: bit stream unpacking, palette store, scaling and result register.
module ppu_back
  import ppu_pkg::*;
#(
  parameter int PALETTE_DEPTH  = 256,
  parameter int MAX_PIXEL_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ppu_cfg_t       cfg_i,
  input  logic           cfg_clear_i,
  input  logic           cmd_valid_i,
  input  ppu_cmd_t       cmd_i,
  output logic           cmd_pop_o,
  output ppu_sts_t       sts_o,
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  // red [7:0], green [15:8], blue [23:16]
  output logic [23:0]    m_axis_tdata_o,
  output logic           m_axis_tlast_o
);

  localparam int BUF_W = MAX_PIXEL_BITS + 8;
  localparam int PXW1  = MAX_PIXEL_BITS + 1;
  localparam int AW    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UNPACK = 2'b10
  } bk_state_e;

  // Configuration-derived pixel layout.
  logic [3:0]               eff_size [NUM_SLOTS];
  logic [HELD_W-1:0]        eff_off  [NUM_SLOTS];
  logic [HELD_W-1:0]        dir_bits;
  logic [3:0]               idx_w;
  logic [HELD_W-1:0]        pix_bits;
  logic [MAX_PIXEL_BITS-1:0] px_mask;
  logic [PXW1-1:0]          one_sh;

  // Unpack engine.
  bk_state_e                state_q, state_d;
  logic [BUF_W-1:0]         buf_q, buf_d;
  logic [HELD_W-1:0]        held_q, held_d;
  logic [FRAME_W-1:0]       done_q, done_d;
  logic                     adv;
  logic                     pal_we;
  logic                     ex_valid;
  logic                     ex_last;
  logic [MAX_PIXEL_BITS-1:0] ex_px;
  logic [AW-1:0]            rd_addr;
  logic                     rd_in_range;

  // Palette store.
  logic [COLOR_W-1:0]       pal_mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] pal_vld_q;
  logic [COLOR_W-1:0]       pal_rd_q;

  // First stage: raw pixel and palette read.
  logic                     s1_valid_q;
  logic                     s1_last_q;
  logic [MAX_PIXEL_BITS-1:0] s1_px_q;
  logic                     s1_rd_ok_q;

  // Second stage: scaled components and palette colour.
  logic [7:0]               fld_mask [NUM_SLOTS];
  logic [7:0]               fld      [NUM_SLOTS];
  logic [PROD_W-1:0]        prod     [NUM_SLOTS];
  logic                     s2_valid_q;
  logic                     s2_last_q;
  logic [7:0]               s2_comp_q [NUM_SLOTS];
  logic [COLOR_W-1:0]       s2_color_q;

  // Result register.
  logic [7:0]               red_c, green_c, blue_c;
  logic                     out_valid_q;
  logic                     out_last_q;
  logic [23:0]              out_data_q;

  always_comb begin : layout
    logic [HELD_W-1:0] used;
    logic [3:0]        v;
    used = '0;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      v = clamp8(cfg_i.slot_bits[j]);
      // Later slots lose bits first when the pixel would grow too wide.
      if ((used + HELD_W'(v)) > HELD_W'(MAX_PIXEL_BITS)) begin
        v = 4'(HELD_W'(MAX_PIXEL_BITS) - used);
      end
      eff_off[j]  = used;
      eff_size[j] = v;
      used        = used + HELD_W'(v);
    end
    dir_bits = used;
  end

  always_comb begin
    if (cfg_i.index_bits == 4'd0) begin
      idx_w = 4'd1;
    end else begin
      idx_w = clamp8(cfg_i.index_bits);
    end
    pix_bits = cfg_i.indexed_mode ? HELD_W'(idx_w) : dir_bits;
    one_sh   = PXW1'(1) << pix_bits;
    px_mask  = MAX_PIXEL_BITS'(one_sh - 1'b1);
  end

  // Bar a layout clear, the back end moves only when the result register is free.
  assign adv       = !out_valid_q || m_axis_tready_i;
  assign cmd_pop_o = adv && !cfg_clear_i && (state_q == ST_IDLE) && cmd_valid_i;

  always_comb begin : engine
    logic [HELD_W-1:0] base_held;
    logic [BUF_W-1:0]  base_buf;
    logic              more;
    state_d   = state_q;
    buf_d     = buf_q;
    held_d    = held_q;
    done_d    = done_q;
    pal_we    = 1'b0;
    ex_valid  = 1'b0;
    ex_last   = 1'b0;
    ex_px     = '0;
    base_held = held_q;
    base_buf  = buf_q;
    more      = 1'b0;
    if (cfg_clear_i) begin
      buf_d   = '0;
      held_d  = '0;
      state_d = ST_IDLE;
    end else if (adv) begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            if (cmd_i.kind == CMD_PAL_WRITE) begin
              pal_we = 1'b1;
            end else begin
              if (cmd_i.sof) begin
                base_held = '0;
                base_buf  = '0;
                done_d    = '0;
              end
              buf_d  = base_buf;
              held_d = base_held;
              // A pixel of no bits at all drops the byte.
              if (pix_bits != '0) begin
                buf_d  = base_buf | (BUF_W'(cmd_i.data_byte) << base_held);
                held_d = base_held + HELD_W'(8);
                if (held_d >= pix_bits) begin
                  state_d = ST_UNPACK;
                end
              end
            end
          end
        end
        ST_UNPACK: begin
          ex_px    = buf_q[MAX_PIXEL_BITS-1:0] & px_mask;
          buf_d    = buf_q >> pix_bits;
          held_d   = held_q - pix_bits;
          ex_valid = (done_q < cfg_i.frame_pixels);
          if (ex_valid) begin
            done_d = done_q + 1'b1;
          end
          more    = (held_d >= pix_bits);
          ex_last = ex_valid && !(more && (done_d < cfg_i.frame_pixels));
          if (!more) begin
            state_d = ST_IDLE;
          end
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  assign rd_addr     = ex_px[AW-1:0];
  assign rd_in_range = ({1'b0, ex_px} < PXW1'(PALETTE_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      buf_q       <= '0;
      held_q      <= '0;
      done_q      <= '0;
      pal_vld_q   <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      buf_q   <= buf_d;
      held_q  <= held_d;
      done_q  <= done_d;
      if (pal_we) begin
        pal_vld_q[cmd_i.pal_index[AW-1:0]] <= 1'b1;
      end
      if (adv) begin
        s1_valid_q  <= ex_valid;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[cmd_i.pal_index[AW-1:0]] <= cmd_i.pal_color;
    end
    if (adv) begin
      pal_rd_q <= pal_mem[rd_addr];
    end
  end

  always_comb begin
    for (int j = 0; j < NUM_SLOTS; j++) begin
      fld_mask[j] = 8'((9'd1 << eff_size[j]) - 9'd1);
      fld[j]      = 8'(s1_px_q >> eff_off[j]) & fld_mask[j];
      prod[j]     = PROD_W'(fld[j]) * PROD_W'(scale_k(eff_size[j]));
    end
  end

  // An entry never written, or an index past the palette, reads as black.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_last_q  <= ex_last;
      s1_px_q    <= ex_px;
      s1_rd_ok_q <= rd_in_range && pal_vld_q[rd_addr];
      s2_last_q  <= s1_last_q;
      s2_color_q <= s1_rd_ok_q ? pal_rd_q : '0;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        s2_comp_q[j] <= prod[j][31:24];
      end
      out_last_q <= s2_last_q;
      out_data_q <= {blue_c, green_c, red_c};
    end
  end

  always_comb begin
    red_c   = '0;
    green_c = '0;
    blue_c  = '0;
    if (cfg_i.indexed_mode) begin
      red_c   = s2_color_q[7:0];
      green_c = s2_color_q[15:8];
      blue_c  = s2_color_q[23:16];
    end else begin
      // Slots are visited in order, so a later slot with the same role wins.
      for (int j = 0; j < NUM_SLOTS; j++) begin
        unique case (cfg_i.slot_roles[2*j +: 2])
          ROLE_RED:   red_c   = s2_comp_q[j];
          ROLE_GREEN: green_c = s2_comp_q[j];
          ROLE_BLUE:  blue_c  = s2_comp_q[j];
          ROLE_ALPHA: ;
        endcase
      end
    end
  end

  assign sts_o.idle     = (state_q == ST_IDLE);
  assign sts_o.held     = held_q;
  assign sts_o.pix_bits = pix_bits;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

### sim/packed_pixel_unpacker_core_checker.sv
// Checker for the packed pixel unpacker: predicts every pixel item and compares what leaves on m_axis.
`timescale 1ns / 100ps

module packed_pixel_unpacker_core_checker
  import ppu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid_i,
  input  logic                 s_axis_tready_i,
  // data_byte [7:0], palette_index [15:8], palette_color [39:16]
  input  logic [39:0]          s_axis_tdata_i,
  // opcode [0], start_of_frame [1]
  input  logic [1:0]           s_axis_tuser_i,
  input  logic                 m_axis_tvalid_i,
  input  logic                 m_axis_tready_i,
  // red [7:0], green [15:8], blue [23:16]
  input  logic [23:0]          m_axis_tdata_i,
  input  logic                 m_axis_tlast_i,
  output int unsigned          errors_o,
  output int unsigned          pending_o
);

  localparam int PAL_ENTRIES = 256;
  localparam int PIXEL_MAX_BITS = 32;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } rgb_pixel_t;

  ppu_cfg_t           regs;
  logic [COLOR_W-1:0] palette [PAL_ENTRIES];
  logic [31:0]        stream_bits;
  logic [HELD_W-1:0]  bits_held;
  logic [FRAME_W-1:0] pixels_done;
  rgb_pixel_t         pixels_due [$];
  int unsigned        errors = 0;

  function automatic logic [63:0] low_bits(input int unsigned n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  // Stretches a field of s bits to the full 8-bit range, rounding down.
  function automatic logic [7:0] to_8bit(input int unsigned v, input int unsigned s);
    if (s == 0) return 8'd0;
    return 8'((v * 255) / ((1 << s) - 1));
  endfunction

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic clear_state();
    regs = '{indexed_mode: 1'b0, index_bits: 4'd8, slot_bits: {4{4'd8}},
             slot_roles: 8'd228, frame_pixels: 24'd307200};
    stream_bits = '0;
    bits_held   = '0;
    pixels_done = '0;
    for (int i = 0; i < PAL_ENTRIES; i++) palette[i] = '0;
    pixels_due.delete();
  endtask

  task automatic write_reg();
    case (cfg_index_i)
      REG_INDEXED_MODE: regs.indexed_mode  = cfg_wdata_i[0];
      REG_INDEX_BITS:   regs.index_bits    = cfg_wdata_i[3:0];
      REG_SLOT0_BITS:   regs.slot_bits[0]  = cfg_wdata_i[3:0];
      REG_SLOT1_BITS:   regs.slot_bits[1]  = cfg_wdata_i[3:0];
      REG_SLOT2_BITS:   regs.slot_bits[2]  = cfg_wdata_i[3:0];
      REG_SLOT3_BITS:   regs.slot_bits[3]  = cfg_wdata_i[3:0];
      REG_SLOT_ROLES:   regs.slot_roles    = cfg_wdata_i[7:0];
      REG_FRAME_PIXELS: regs.frame_pixels  = cfg_wdata_i[FRAME_W-1:0];
      default: ;
    endcase
    // Any write but the frame size throws away the partial pixel.
    if (cfg_index_i != REG_FRAME_PIXELS) begin
      stream_bits = '0;
      bits_held   = '0;
    end
  endtask

  task automatic unpack_byte(input logic [7:0] din, input logic sof);
    int unsigned        width [NUM_SLOTS];
    int unsigned        used;
    int unsigned        pix_bits;
    int unsigned        held;
    int unsigned        off;
    int unsigned        iter;
    int unsigned        field;
    logic [63:0]        stream;
    logic [31:0]        px;
    logic [COLOR_W-1:0] color;
    logic [1:0]         role;
    rgb_pixel_t         prev;
    logic               have_prev;

    if (sof) begin
      stream_bits = '0;
      bits_held   = '0;
      pixels_done = '0;
    end

    used = 0;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      width[j] = (regs.slot_bits[j] > 4'd8) ? 8 : regs.slot_bits[j];
      if (used + width[j] > PIXEL_MAX_BITS) width[j] = PIXEL_MAX_BITS - used;
      used += width[j];
    end
    if (regs.indexed_mode)
      pix_bits = (regs.index_bits == 4'd0) ? 1 : ((regs.index_bits > 4'd8) ? 8 : regs.index_bits);
    else
      pix_bits = used;
    // A pixel of no bits at all swallows the byte.
    if (pix_bits == 0) return;

    held      = bits_held;
    stream    = (64'(stream_bits) & low_bits(held)) | (64'(din) << held);
    held     += 8;
    iter      = 0;
    have_prev = 1'b0;
    while (held >= pix_bits && iter < 8) begin
      px      = 32'(stream & low_bits(pix_bits));
      stream  = stream >> pix_bits;
      held   -= pix_bits;
      iter++;
      if (pixels_done < regs.frame_pixels) begin
        pixels_done++;
        if (regs.indexed_mode) begin
          color = palette[px[7:0]];
        end else begin
          color = '0;
          off   = 0;
          // Slots are visited in order, so a later slot overrides an earlier one of the same role.
          for (int j = 0; j < NUM_SLOTS; j++) begin
            field = 32'((64'(px) >> off) & low_bits(width[j]));
            role  = regs.slot_roles[2*j +: 2];
            off  += width[j];
            case (role)
              ROLE_RED:   color[7:0]   = to_8bit(field, width[j]);
              ROLE_GREEN: color[15:8]  = to_8bit(field, width[j]);
              ROLE_BLUE:  color[23:16] = to_8bit(field, width[j]);
              default: ;
            endcase
          end
        end
        if (have_prev) pixels_due.push_back(prev);
        prev      = '{red: color[7:0], green: color[15:8], blue: color[23:16], last: 1'b0};
        have_prev = 1'b1;
      end
    end
    stream_bits = 32'(stream & low_bits(held));
    bits_held   = HELD_W'(held);
    if (have_prev) begin
      prev.last = 1'b1;
      pixels_due.push_back(prev);
    end
  endtask

  task automatic check_pixel();
    rgb_pixel_t want;
    if (pixels_due.size() == 0) begin
      report("pixel item with none due", m_axis_tdata_i, 0);
      return;
    end
    want = pixels_due.pop_front();
    if (m_axis_tdata_i[7:0] !== want.red)    report("red", m_axis_tdata_i[7:0], want.red);
    if (m_axis_tdata_i[15:8] !== want.green) report("green", m_axis_tdata_i[15:8], want.green);
    if (m_axis_tdata_i[23:16] !== want.blue) report("blue", m_axis_tdata_i[23:16], want.blue);
    if (m_axis_tlast_i !== want.last)        report("tlast", m_axis_tlast_i, want.last);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_state();
    end else begin
      if (cfg_we_i) write_reg();
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (s_axis_tuser_i[0] == CMD_PAL_WRITE)
          palette[s_axis_tdata_i[15:8]] = s_axis_tdata_i[39:16];
        else
          unpack_byte(s_axis_tdata_i[7:0], s_axis_tuser_i[1]);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) check_pixel();
    end
    errors_o  <= errors;
    pending_o <= pixels_due.size();
  end

endmodule

### sim/packed_pixel_unpacker_core_tb.sv
// Testbench top for the packed pixel unpacker: drives bytes, palette writes and registers.
`timescale 1ns / 100ps

module packed_pixel_unpacker_core_tb;
  import ppu_pkg::*;

  localparam int RANDOM_ITEMS  = 130;
  localparam int SETTLE_CYCLES = 60;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [39:0]          s_tdata   = '0;
  logic [1:0]           s_tuser   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [23:0]          m_tdata;
  logic                 m_tlast;
  int unsigned          errors;
  int unsigned          pending;
  logic                 send_calm = 1'b0;
  logic                 recv_calm = 1'b0;
  ppu_cfg_t             next_cfg  = CFG_RESET;

  always #2 clk = ~clk;

  packed_pixel_unpacker_core i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  packed_pixel_unpacker_core_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tlast_i  (m_tlast),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  // Presents one item after a random gap and returns at the edge that accepts it.
  task automatic send_item(input cmd_kind_e kind, input logic sof, input logic [7:0] data,
                           input logic [7:0] idx, input logic [COLOR_W-1:0] color);
    int gap;
    if ($urandom_range(0, 11) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {color, idx, data};
    s_tuser  <= {sof, kind};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_byte(input logic sof, input logic [7:0] data);
    send_item(CMD_PIXEL, sof, data, 8'($urandom), COLOR_W'($urandom));
  endtask

  task automatic send_palette(input logic [7:0] idx, input logic [COLOR_W-1:0] color);
    send_item(CMD_PAL_WRITE, 1'($urandom), 8'($urandom), idx, color);
  endtask

  // Holds the input off until every pixel due has left, then waits a further settle time.
  task automatic drain(input int settle);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic reconfigure();
    logic [CFG_W-1:0] value;
    drain(SETTLE_CYCLES);
    for (int r = 0; r < 8; r++) begin
      case (CFG_IDX_W'(r))
        REG_INDEXED_MODE: value = CFG_W'(next_cfg.indexed_mode);
        REG_INDEX_BITS:   value = CFG_W'(next_cfg.index_bits);
        REG_SLOT0_BITS:   value = CFG_W'(next_cfg.slot_bits[0]);
        REG_SLOT1_BITS:   value = CFG_W'(next_cfg.slot_bits[1]);
        REG_SLOT2_BITS:   value = CFG_W'(next_cfg.slot_bits[2]);
        REG_SLOT3_BITS:   value = CFG_W'(next_cfg.slot_bits[3]);
        REG_SLOT_ROLES:   value = CFG_W'(next_cfg.slot_roles);
        REG_FRAME_PIXELS: value = CFG_W'(next_cfg.frame_pixels);
        default:          value = '0;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_wdata <= value;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int stall;
    forever begin
      if ($urandom_range(0, 11) == 0) recv_calm = !recv_calm;
      stall = recv_calm ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin
    int sent;
    int phase_len;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: four 8-bit slots, the last one alpha.
    send_byte(1'b1, 8'hFF);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'h80);
    send_byte(1'b0, 8'h7F);
    send_palette(8'h00, 24'hFFFFFF);
    send_palette(8'hFF, 24'hA5C35A);
    send_item(CMD_PAL_WRITE, 1'b1, 8'h00, 8'h01, 24'h00FF00);

    // One bit per index gives eight pixels per byte.
    next_cfg.indexed_mode = 1'b1;
    next_cfg.index_bits   = 4'd1;
    next_cfg.frame_pixels = 24'hFFFFFF;
    reconfigure();
    send_byte(1'b1, 8'h01);
    send_byte(1'b0, 8'hFE);

    next_cfg.index_bits = 4'd8;
    reconfigure();
    send_byte(1'b1, 8'hFF);
    send_byte(1'b0, 8'h00);

    // Out-of-range index widths are clamped to one and to eight.
    next_cfg.index_bits = 4'd0;
    reconfigure();
    send_byte(1'b0, 8'h5A);
    next_cfg.index_bits = 4'd15;
    reconfigure();
    send_byte(1'b0, 8'h01);

    // Every slot empty: the byte yields nothing.
    next_cfg.indexed_mode = 1'b0;
    next_cfg.slot_bits    = '0;
    reconfigure();
    send_byte(1'b1, 8'hFF);

    // Oversized first slot, and green given twice with the empty slot winning.
    next_cfg.slot_bits[0] = 4'd15;
    next_cfg.slot_bits[1] = 4'd1;
    next_cfg.slot_bits[2] = 4'd7;
    next_cfg.slot_bits[3] = 4'd0;
    next_cfg.slot_roles   = {ROLE_GREEN, ROLE_BLUE, ROLE_GREEN, ROLE_RED};
    reconfigure();
    send_byte(1'b1, 8'hFF);
    send_byte(1'b0, 8'h80);

    // A one-pixel frame: later pixels are consumed but dropped.
    next_cfg.slot_bits[0] = 4'd5;
    next_cfg.slot_bits[1] = 4'd6;
    next_cfg.slot_bits[2] = 4'd5;
    next_cfg.slot_roles   = {ROLE_ALPHA, ROLE_BLUE, ROLE_GREEN, ROLE_RED};
    next_cfg.frame_pixels = 24'd1;
    reconfigure();
    send_byte(1'b1, 8'hFF);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h12);
    send_byte(1'b0, 8'h34);

    next_cfg.frame_pixels = 24'd0;
    reconfigure();
    send_byte(1'b1, 8'hAB);
    send_byte(1'b0, 8'hCD);

    // No slot carries a colour, so every component reads as zero.
    next_cfg.frame_pixels = 24'hFFFFFF;
    next_cfg.slot_roles   = {4{ROLE_ALPHA}};
    reconfigure();
    send_byte(1'b1, 8'h3C);
    send_byte(1'b0, 8'hC3);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      next_cfg.indexed_mode = 1'($urandom);
      next_cfg.index_bits   = ($urandom_range(0, 4) == 0) ? 4'($urandom)
                                                          : 4'($urandom_range(1, 8));
      for (int j = 0; j < NUM_SLOTS; j++)
        next_cfg.slot_bits[j] = ($urandom_range(0, 5) == 0) ? 4'($urandom)
                                                            : 4'($urandom_range(0, 8));
      next_cfg.slot_roles = 8'($urandom);
      case ($urandom_range(0, 3))
        0:       next_cfg.frame_pixels = FRAME_W'($urandom_range(0, 12));
        1:       next_cfg.frame_pixels = 24'hFFFFFF;
        default: next_cfg.frame_pixels = FRAME_W'($urandom);
      endcase
      reconfigure();
      phase_len = $urandom_range(10, 30);
      for (int k = 0; k < phase_len; k++) begin
        if ($urandom_range(0, 29) == 0) drain(0);
        if ($urandom_range(0, 99) < 15)
          send_palette(8'($urandom), COLOR_W'($urandom));
        else
          // Most phases open a fresh frame; a stray start of frame turns up now and then.
          send_byte((k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 15) == 0),
                    8'($urandom));
        sent++;
      end
    end

    drain(SETTLE_CYCLES);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
